>>> hdl/qss_pkg.sv
// Shared types and constants for the quicksort integer sorter.
package qss_pkg;

    // Key width on the channel payloads
    localparam int unsigned PORT_KEY_W = 32;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_POP,
        ST_POP_WAIT,
        ST_PIVOT,
        ST_PIVOT_LD,
        ST_READ,
        ST_CMP,
        ST_SWAP2,
        ST_FIN_RD,
        ST_FIN_A,
        ST_FIN_B,
        ST_EMIT_RD,
        ST_EMIT_PUT
    } t_state;

endpackage

>>> hdl/qss_if.sv
// Valid/ready channel interfaces for keys in and sorted keys out.
interface qss_in_if import qss_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic signed [PORT_KEY_W-1:0] key_value;
    logic                         is_last;

    modport source (output valid, output key_value, output is_last, input ready);
    modport sink   (input valid, input key_value, input is_last, output ready);
endinterface

interface qss_out_if import qss_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic signed [PORT_KEY_W-1:0] sorted_value;
    logic                         last_out;
    logic                         dropped;

    modport source (output valid, output sorted_value, output last_out, output dropped,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input dropped,
                    output ready);
endinterface

>>> hdl/qss_key_ram.sv
// Key store: one write port, two registered read ports.
module qss_key_ram import qss_pkg::*; #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr_b,
    output logic [WIDTH-1:0]                 o_rdata_a,
    output logic [WIDTH-1:0]                 o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read returns the value held before a write at the same edge
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> hdl/quicksort_integer_sorter.sv
// Quicksort integer sorter top level: load, Lomuto partition sort, ordered emit.
//
//  channel   | dir | payload                               | transaction
//  ----------+-----+---------------------------------------+----------------------
//  i_key     | in  | key_value[31:0], is_last              | valid && ready
//  o_sorted  | out | sorted_value[31:0], last_out, dropped | valid && ready
//
// Loading takes one key per cycle. After the key marked last the block sorts in
// place with one comparator and a two-read, one-write key RAM: each scanned key of
// a range is read, then compared, and a swapped key takes an extra write state.
// Emitting reads each key, then puts it; the output register lets the next set start
// loading while the last key still waits. Synchronous active-low reset clears
// control state only; i_key is held not ready from the last key until the final
// sorted key sits in the output register.
module quicksort_integer_sorter import qss_pkg::*; #(
    parameter int unsigned CAPACITY = 64,
    parameter int unsigned KEY_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qss_in_if.sink    i_key,
    qss_out_if.source o_sorted
);

    localparam int unsigned KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned SW = 2 * IW;

    t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_sp, n_sp;
    logic          r_ovf, n_ovf;
    logic [IW-1:0] r_lo, n_lo;
    logic [IW-1:0] r_hi, n_hi;
    logic [IW-1:0] r_j, n_j;
    logic [IW-1:0] r_place, n_place;
    logic signed [KW-1:0] r_pivot, n_pivot;

    logic                         r_out_valid, n_out_valid;
    logic signed [PORT_KEY_W-1:0] r_out_data, n_out_data;
    logic                         r_out_last, n_out_last;
    logic                         r_out_drop, n_out_drop;

    // key RAM controls
    logic                 key_we;
    logic [IW-1:0]        key_waddr;
    logic signed [KW-1:0] key_wdata;
    logic [IW-1:0]        key_raddr_a;
    logic [IW-1:0]        key_raddr_b;
    logic signed [KW-1:0] key_rd_a;
    logic signed [KW-1:0] key_rd_b;

    // range stack: {lo, hi}
    logic [SW-1:0] r_stack [CAPACITY];
    logic [SW-1:0] r_stk_rd;
    logic          stk_we;
    logic [IW-1:0] stk_waddr;
    logic [SW-1:0] stk_wdata;
    logic [IW-1:0] stk_raddr;

    logic          in_acc;
    logic          out_free;
    logic          scan_end;
    logic          j_is_last;

    qss_key_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KW)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_we      (key_we),
        .i_waddr   (key_waddr),
        .i_wdata   (key_wdata),
        .i_raddr_a (key_raddr_a),
        .i_raddr_b (key_raddr_b),
        .o_rdata_a (key_rd_a),
        .o_rdata_b (key_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_waddr] <= stk_wdata;
        end
        r_stk_rd <= r_stack[stk_raddr];
    end

    assign i_key.ready           = (r_state == ST_LOAD);
    assign in_acc                = i_key.valid && (r_state == ST_LOAD);
    assign out_free              = !r_out_valid || o_sorted.ready;
    assign scan_end              = ({1'b0, r_j} + (IW+1)'(1)) == {1'b0, r_hi};
    assign j_is_last             = (CW'(r_j) == (r_count - CW'(1)));

    assign o_sorted.valid        = r_out_valid;
    assign o_sorted.sorted_value = r_out_data;
    assign o_sorted.last_out     = r_out_last;
    assign o_sorted.dropped      = r_out_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_sp        <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sp        <= n_sp;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_j        <= n_j;
        r_place    <= n_place;
        r_pivot    <= n_pivot;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_drop <= n_out_drop;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sp        = r_sp;
        n_ovf       = r_ovf;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_j         = r_j;
        n_place     = r_place;
        n_pivot     = r_pivot;
        n_out_valid = r_out_valid && !o_sorted.ready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_drop  = r_out_drop;

        key_we      = 1'b0;
        key_waddr   = r_place;
        key_wdata   = key_rd_a;
        key_raddr_a = r_j;
        key_raddr_b = r_place;

        stk_we      = 1'b0;
        stk_waddr   = r_sp[IW-1:0];
        stk_wdata   = {r_lo, r_hi};
        stk_raddr   = IW'(r_sp - CW'(1));

        unique case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (r_count < CW'(CAPACITY)) begin
                        key_we    = 1'b1;
                        key_waddr = r_count[IW-1:0];
                        key_wdata = i_key.key_value[KW-1:0];
                        n_count   = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_key.is_last) begin
                        n_state = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                if (r_count >= CW'(2)) begin
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = {IW'(0), IW'(r_count - CW'(1))};
                    n_sp      = CW'(1);
                    n_state   = ST_POP;
                end else begin
                    n_j     = '0;
                    n_state = ST_EMIT_RD;
                end
            end
            ST_POP: begin
                n_sp    = r_sp - CW'(1);
                n_state = ST_POP_WAIT;
            end
            ST_POP_WAIT: begin
                n_lo    = r_stk_rd[SW-1:IW];
                n_hi    = r_stk_rd[IW-1:0];
                n_j     = r_stk_rd[SW-1:IW];
                n_place = r_stk_rd[SW-1:IW];
                n_state = ST_PIVOT;
            end
            ST_PIVOT: begin
                key_raddr_a = r_hi;
                n_state     = ST_PIVOT_LD;
            end
            ST_PIVOT_LD: begin
                n_pivot = key_rd_a;
                n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                // port A holds key[j], port B key[place]
                if (key_rd_a <= r_pivot) begin
                    key_we    = 1'b1;
                    key_waddr = r_place;
                    key_wdata = key_rd_a;
                    n_state   = ST_SWAP2;
                end else if (scan_end) begin
                    n_state = ST_FIN_RD;
                end else begin
                    n_j     = r_j + IW'(1);
                    n_state = ST_READ;
                end
            end
            ST_SWAP2: begin
                key_we    = 1'b1;
                key_waddr = r_j;
                key_wdata = key_rd_b;
                n_place   = r_place + IW'(1);
                if (scan_end) begin
                    n_state = ST_FIN_RD;
                end else begin
                    n_j     = r_j + IW'(1);
                    n_state = ST_READ;
                end
            end
            ST_FIN_RD: begin
                n_state = ST_FIN_A;
            end
            ST_FIN_A: begin
                key_we    = 1'b1;
                key_waddr = r_hi;
                key_wdata = key_rd_b;
                // left part holds two or more keys and the stack has room
                if ({1'b0, r_place} > ({1'b0, r_lo} + (IW+1)'(1))
                        && r_sp < CW'(CAPACITY)) begin
                    stk_we    = 1'b1;
                    stk_wdata = {r_lo, r_place - IW'(1)};
                    n_sp      = r_sp + CW'(1);
                end
                n_state = ST_FIN_B;
            end
            ST_FIN_B: begin
                key_we    = 1'b1;
                key_waddr = r_place;
                key_wdata = r_pivot;
                if (({1'b0, r_place} + (IW+1)'(1)) < {1'b0, r_hi}
                        && r_sp < CW'(CAPACITY)) begin
                    stk_we    = 1'b1;
                    stk_wdata = {r_place + IW'(1), r_hi};
                    n_sp      = r_sp + CW'(1);
                end
                if (n_sp != '0) begin
                    n_state = ST_POP;
                end else begin
                    n_j     = '0;
                    n_state = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_PUT;
            end
            ST_EMIT_PUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = PORT_KEY_W'(key_rd_a);
                    n_out_last  = j_is_last;
                    n_out_drop  = r_ovf;
                    if (j_is_last) begin
                        n_count = '0;
                        n_sp    = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_j     = r_j + IW'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the quicksort integer sorter: keys in, sorted keys out.
`timescale 1ns / 1ps

module testbench;
    import qss_pkg::*;

    localparam int unsigned CAPACITY    = 64;
    localparam int unsigned KEY_TARGET  = 450;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES = 50;
    localparam longint unsigned CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [PORT_KEY_W-1:0] key;
        logic                  last;
    } t_key_item;

    typedef struct packed {
        logic [PORT_KEY_W-1:0] value;
        logic                  last;
        logic                  dropped;
    } t_sorted_key;

    logic clk;
    logic rst_n;

    qss_in_if  key_if ();
    qss_out_if sorted_if ();

    quicksort_integer_sorter u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_key    (key_if),
        .o_sorted (sorted_if)
    );

    t_key_item                   pending_keys[$];
    logic signed [PORT_KEY_W-1:0] set_keys[$];
    logic                        set_overflow;
    t_sorted_key                 expected_sorted[$];

    t_key_item       next_item;
    t_sorted_key     got_key;
    t_sorted_key     want_key;
    logic            key_taken;
    int unsigned     keys_queued;
    int unsigned     keys_accepted;
    int unsigned     error_count;
    int unsigned     hold_left;
    logic            hold_done;
    longint unsigned cycle_count;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver idles more in the first stretch, sender in the second, neither at the end
    function automatic int unsigned idle_mode();
        if (keys_accepted < 160)
            return 0;
        else if (keys_accepted < 320)
            return 1;
        return 2;
    endfunction

    function automatic logic sender_idles();
        int unsigned pct;
        pct = (idle_mode() == 0) ? 26 : (idle_mode() == 1) ? 46 : 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic receiver_idles();
        int unsigned pct;
        pct = (idle_mode() == 0) ? 46 : (idle_mode() == 1) ? 26 : 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic signed [PORT_KEY_W-1:0] random_key();
        int unsigned pick;
        int          near_zero;
        pick = $urandom_range(0, 9);
        near_zero = int'($urandom_range(0, 15)) - 8;
        case (pick)
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3: return near_zero;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_key(input logic signed [PORT_KEY_W-1:0] key, input logic last);
        t_key_item item;
        item.key  = key;
        item.last = last;
        pending_keys.push_back(item);
        keys_queued++;
    endtask

    // Ascending, descending and flat runs push the partition to its worst depth; most sets are random
    task automatic queue_random_set(input int unsigned set_size);
        int unsigned                  pattern;
        logic signed [PORT_KEY_W-1:0] base;
        logic signed [PORT_KEY_W-1:0] key;
        pattern = $urandom_range(0, 9);
        base = random_key();
        for (int unsigned i = 0; i < set_size; i++) begin
            case (pattern)
                0:       key = base + i;
                1:       key = base - i;
                2:       key = base;
                default: key = random_key();
            endcase
            queue_key(key, i == set_size - 1);
        end
    endtask

    // Store model: keys past capacity are lost; the last key closes the set and
    // yields every stored key in ascending order
    task automatic predict_sorted_set(input logic signed [PORT_KEY_W-1:0] key,
                                      input logic last);
        logic signed [PORT_KEY_W-1:0] shifted;
        t_sorted_key                  res;
        int                           j;
        if (set_keys.size() < CAPACITY)
            set_keys.push_back(key);
        else
            set_overflow = 1'b1;
        if (last) begin
            for (int i = 1; i < set_keys.size(); i++) begin
                shifted = set_keys[i];
                j = i - 1;
                while (j >= 0 && set_keys[j] > shifted) begin
                    set_keys[j + 1] = set_keys[j];
                    j--;
                end
                set_keys[j + 1] = shifted;
            end
            for (int i = 0; i < set_keys.size(); i++) begin
                res.value   = set_keys[i];
                res.last    = (i == set_keys.size() - 1);
                res.dropped = set_overflow;
                expected_sorted.push_back(res);
            end
            set_keys.delete();
            set_overflow = 1'b0;
        end
    endtask

    initial begin
        key_if.valid     = 1'b0;
        key_if.key_value = '0;
        key_if.is_last   = 1'b0;
        sorted_if.ready  = 1'b0;
        set_overflow     = 1'b0;
        key_taken        = 1'b0;
        keys_queued      = 0;
        keys_accepted    = 0;
        error_count      = 0;
        hold_left        = 0;
        hold_done        = 1'b0;
        cycle_count      = 0;
        rst_n            = 1'b0;

        // single-key set
        queue_key(32'sd7, 1'b1);
        // extremes of the key range
        queue_key(32'sh7FFF_FFFF, 1'b0);
        queue_key(32'sh8000_0000, 1'b0);
        queue_key(32'sd0, 1'b0);
        queue_key(-32'sd1, 1'b0);
        queue_key(32'sd1, 1'b1);
        // duplicates, equal to the pivot
        queue_key(32'sd5, 1'b0);
        queue_key(-32'sd3, 1'b0);
        queue_key(32'sd5, 1'b0);
        queue_key(32'sd5, 1'b0);
        queue_key(-32'sd3, 1'b1);
        // already ascending, then descending
        for (int i = 0; i < 5; i++)
            queue_key(i * 1000 - 2000, i == 4);
        for (int i = 0; i < 5; i++)
            queue_key(2000 - i * 1000, i == 4);

        // store full, the marked key among those discarded
        queue_random_set(CAPACITY + 3);
        while (keys_queued < KEY_TARGET) begin
            case ($urandom_range(0, 99)) inside
                [0:69]:  queue_random_set($urandom_range(1, 12));
                [70:81]: queue_random_set($urandom_range(13, 40));
                [82:91]: queue_random_set(CAPACITY);
                default: queue_random_set($urandom_range(CAPACITY + 1, CAPACITY + 8));
            endcase
        end

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        while (pending_keys.size() != 0 || key_if.valid)
            @(posedge clk);
        while (expected_sorted.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Key driver
    always @(negedge clk) begin
        if (!rst_n) begin
            key_if.valid <= 1'b0;
        end else if (!key_if.valid || key_taken) begin
            if (pending_keys.size() != 0 && !sender_idles()) begin
                next_item = pending_keys.pop_front();
                key_if.valid     <= 1'b1;
                key_if.key_value <= next_item.key;
                key_if.is_last   <= next_item.last;
            end else begin
                key_if.valid <= 1'b0;
            end
        end
    end

    // Receiver, with one long hold-off mid-set so the sorter backs up onto its input
    always @(negedge clk) begin
        if (!rst_n) begin
            sorted_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            sorted_if.ready <= 1'b0;
        end else if (!hold_done && keys_accepted >= 120 && sorted_if.valid
                     && !sorted_if.last_out) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            sorted_if.ready <= 1'b0;
        end else begin
            sorted_if.ready <= !receiver_idles();
        end
    end

    // Input transactions feed the store model
    always @(posedge clk) begin
        key_taken = rst_n && key_if.valid && key_if.ready;
        if (key_taken) begin
            keys_accepted++;
            predict_sorted_set(key_if.key_value, key_if.is_last);
        end
    end

    // Output transactions checked against the oldest expected key
    always @(posedge clk) begin
        if (rst_n && sorted_if.valid && sorted_if.ready) begin
            got_key.value   = sorted_if.sorted_value;
            got_key.last    = sorted_if.last_out;
            got_key.dropped = sorted_if.dropped;
            if (expected_sorted.size() == 0) begin
                error_count++;
                $display("%0t: unexpected key %0d last %0b dropped %0b", $time,
                         $signed(got_key.value), got_key.last, got_key.dropped);
            end else begin
                want_key = expected_sorted.pop_front();
                if (got_key.value !== want_key.value) begin
                    error_count++;
                    $display("%0t: sorted_value expected %0d got %0d", $time,
                             $signed(want_key.value), $signed(got_key.value));
                end
                if (got_key.last !== want_key.last) begin
                    error_count++;
                    $display("%0t: last_out expected %0b got %0b", $time,
                             want_key.last, got_key.last);
                end
                if (got_key.dropped !== want_key.dropped) begin
                    error_count++;
                    $display("%0t: dropped expected %0b got %0b", $time,
                             want_key.dropped, got_key.dropped);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

>>> files.f
hdl/qss_pkg.sv
hdl/qss_if.sv
hdl/qss_key_ram.sv
hdl/quicksort_integer_sorter.sv
tb/testbench.sv
